### src/ttcc_pkg.sv
// Shared types and constants of the text terminal cursor controller.
// Used by the controller, the datapath, the top level and the testbench.
package ttcc_pkg;

  // Grid size limits; the effective grid never exceeds the field widths.
  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 128;
  localparam int COL_LIMIT   = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
  localparam int ROW_LIMIT   = (MAX_ROWS < 128) ? MAX_ROWS : 128;

  // Configuration register indexes
  localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [1:0] REG_FOREGROUND   = 2'd2;
  localparam logic [1:0] REG_BACKGROUND   = 2'd3;

  localparam logic [8:0]  COLUMN_COUNT_RESET = 9'd80;
  localparam logic [7:0]  ROW_COUNT_RESET    = 8'd25;
  localparam logic [31:0] FOREGROUND_RESET   = 32'h00FF_FFFF;
  localparam logic [31:0] BACKGROUND_RESET   = 32'h001A_1A2E;

  // Command opcodes
  localparam logic [1:0] OP_PUT_CHAR = 2'd0;
  localparam logic [1:0] OP_SET_CUR  = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Character codes with special handling
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [6:0] GLYPH_SPACE  = 7'd32;

  localparam int TAB_STOP = 4;

  typedef enum logic [2:0] {
    IK_NONE,
    IK_SET,
    IK_CLEAR,
    IK_NEWLINE,
    IK_RETURN,
    IK_BACKSPACE,
    IK_TAB,
    IK_PUT
  } item_kind_t;

  typedef enum logic [2:0] {
    ACT_IDLE,
    ACT_SET,
    ACT_CLEAR,
    ACT_NEWLINE,
    ACT_RETURN,
    ACT_BACKSPACE,
    ACT_PUT,
    ACT_SCROLL
  } act_t;

  typedef struct packed {
    logic load;   // capture the accepted item
    act_t act;
    logic last;   // result emitted by this action ends the item
  } ctrl_cmd_t;

  typedef struct packed {
    item_kind_t kind;
    logic       wrap;        // advancing passes the last column
    logic       last_row;
    logic       count_last;  // one cell left to put
    logic       count_zero;
    logic       out_free;    // output register can take a result
  } dp_status_t;

endpackage

### src/ttcc_if.sv
// Stream interfaces for the command and result channels.
// Depends on nothing but the field widths of the block.
interface ttcc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] character;
  logic [6:0] target_row;
  logic [7:0] target_column;

  modport source (output valid, opcode, character, target_row, target_column,
                  input ready);
  modport sink (input valid, opcode, character, target_row, target_column,
                output ready);
endinterface

interface ttcc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  cell_column;
  logic [6:0]  cell_row;
  logic [6:0]  glyph_code;
  logic [31:0] ink_color;
  logic [31:0] paper_color;
  logic        final_res;

  modport source (output valid, kind, cell_column, cell_row, glyph_code, ink_color,
                  paper_color, final_res, input ready);
  modport sink (input valid, kind, cell_column, cell_row, glyph_code, ink_color,
                paper_color, final_res, output ready);
endinterface

### src/ttcc_ctrl.sv
// Sequencer of the cursor controller: accepts an item, then steps the
// datapath through its actions one result at a time. Uses ttcc_pkg.
module ttcc_ctrl
  import ttcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PUT,
    S_SCROLL
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '{load: 1'b0, act: ACT_IDLE, last: 1'b0};
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status.kind)
          IK_NONE: state_next = S_IDLE;
          IK_SET: begin
            cmd.act    = ACT_SET;
            state_next = S_IDLE;
          end
          IK_CLEAR: begin
            if (status.out_free) begin
              cmd.act    = ACT_CLEAR;
              cmd.last   = 1'b1;
              state_next = S_IDLE;
            end
          end
          IK_NEWLINE: begin
            if (status.out_free) begin
              cmd.act    = ACT_NEWLINE;
              cmd.last   = 1'b1;
              state_next = S_IDLE;
            end
          end
          IK_RETURN: begin
            cmd.act    = ACT_RETURN;
            state_next = S_IDLE;
          end
          IK_BACKSPACE: begin
            cmd.act    = ACT_BACKSPACE;
            state_next = S_IDLE;
          end
          IK_TAB, IK_PUT: state_next = S_PUT;
          default: state_next = S_IDLE;
        endcase
      end
      S_PUT: begin
        if (status.out_free) begin
          cmd.act  = ACT_PUT;
          cmd.last = status.count_last && !(status.wrap && status.last_row);
          if (status.wrap && status.last_row) begin
            state_next = S_SCROLL;
          end else if (status.count_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SCROLL: begin
        if (status.out_free) begin
          cmd.act    = ACT_SCROLL;
          cmd.last   = status.count_zero;
          state_next = status.count_zero ? S_IDLE : S_PUT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/ttcc_datapath.sv
// Datapath of the cursor controller: configuration registers, cursor,
// the captured item, the cell counter and the result register. Uses ttcc_pkg.
module ttcc_datapath
  import ttcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  opcode,
  input  logic [7:0]  character,
  input  logic [6:0]  target_row,
  input  logic [7:0]  target_column,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  cell_column,
  output logic [6:0]  cell_row,
  output logic [6:0]  glyph_code,
  output logic [31:0] ink_color,
  output logic [31:0] paper_color,
  output logic        final_res
);

  logic [8:0]  column_count;
  logic [7:0]  row_count;
  logic [31:0] foreground_color;
  logic [31:0] background_color;

  logic [7:0] cursor_column;
  logic [6:0] cursor_row;
  logic [1:0] item_op;
  logic [7:0] item_char;
  logic [6:0] item_trow;
  logic [7:0] item_tcol;
  logic [2:0] cell_count;

  logic [8:0]  eff_cols;
  logic [7:0]  eff_rows;
  logic [7:0]  col_max;
  logic [6:0]  row_max;
  logic [7:0]  col_sat;
  logic [6:0]  row_sat;
  logic        emit;
  item_kind_t  item_kind;

  // Effective grid, saturated to at least one cell and to the limits
  always_comb begin
    if (column_count == 9'd0) begin
      eff_cols = 9'd1;
    end else if (column_count > 9'(COL_LIMIT)) begin
      eff_cols = 9'(COL_LIMIT);
    end else begin
      eff_cols = column_count;
    end
    if (row_count == 8'd0) begin
      eff_rows = 8'd1;
    end else if (row_count > 8'(ROW_LIMIT)) begin
      eff_rows = 8'(ROW_LIMIT);
    end else begin
      eff_rows = row_count;
    end
  end

  assign col_max = 8'(eff_cols - 9'd1);
  assign row_max = 7'(eff_rows - 8'd1);
  assign col_sat = ({1'b0, cursor_column} >= eff_cols) ? col_max : cursor_column;
  assign row_sat = ({1'b0, cursor_row} >= eff_rows) ? row_max : cursor_row;

  always_comb begin
    item_kind = IK_NONE;
    case (item_op)
      OP_PUT_CHAR: begin
        if (item_char == CH_NEWLINE) begin
          item_kind = IK_NEWLINE;
        end else if (item_char == CH_RETURN) begin
          item_kind = IK_RETURN;
        end else if (item_char == CH_BACKSPACE) begin
          item_kind = IK_BACKSPACE;
        end else if (item_char == CH_TAB) begin
          item_kind = IK_TAB;
        end else begin
          item_kind = IK_PUT;
        end
      end
      OP_SET_CUR: item_kind = IK_SET;
      OP_CLEAR:   item_kind = IK_CLEAR;
      default:    item_kind = IK_NONE;
    endcase
  end

  assign status.kind       = item_kind;
  assign status.wrap       = ({1'b0, cursor_column} + 9'd1) >= eff_cols;
  assign status.last_row   = ({1'b0, cursor_row} + 8'd1) >= eff_rows;
  assign status.count_last = (cell_count == 3'd1);
  assign status.count_zero = (cell_count == 3'd0);
  assign status.out_free   = !out_valid || out_ready;

  always_comb begin
    unique case (cmd.act)
      ACT_CLEAR, ACT_SCROLL: emit = 1'b1;
      ACT_NEWLINE:           emit = status.last_row;
      ACT_PUT:               emit = !item_char[7];
      default:               emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= COLUMN_COUNT_RESET;
      row_count        <= ROW_COUNT_RESET;
      foreground_color <= FOREGROUND_RESET;
      background_color <= BACKGROUND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMN_COUNT: column_count     <= cfg_data[8:0];
        REG_ROW_COUNT:    row_count        <= cfg_data[7:0];
        REG_FOREGROUND:   foreground_color <= cfg_data;
        REG_BACKGROUND:   background_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Cursor and item registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
      item_op       <= OP_PUT_CHAR;
      item_char     <= '0;
      cell_count    <= '0;
    end else if (cmd.load) begin
      item_op       <= opcode;
      item_char     <= character;
      item_trow     <= target_row;
      item_tcol     <= target_column;
      cursor_column <= col_sat;
      cursor_row    <= row_sat;
      // tab fills up to the next stop; anything else puts one cell
      cell_count    <= (character == CH_TAB) ?
                       (3'(TAB_STOP) - {1'b0, col_sat[1:0]}) : 3'd1;
    end else begin
      unique case (cmd.act)
        ACT_SET: begin
          cursor_row    <= ({1'b0, item_trow} >= eff_rows) ? row_max : item_trow;
          cursor_column <= ({1'b0, item_tcol} >= eff_cols) ? col_max : item_tcol;
        end
        ACT_CLEAR: begin
          cursor_column <= '0;
          cursor_row    <= '0;
        end
        ACT_NEWLINE: begin
          cursor_column <= '0;
          if (!status.last_row) begin
            cursor_row <= cursor_row + 7'd1;
          end
        end
        ACT_RETURN: cursor_column <= '0;
        ACT_BACKSPACE: begin
          if (cursor_column != 8'd0) begin
            cursor_column <= cursor_column - 8'd1;
          end
        end
        ACT_PUT: begin
          cell_count <= cell_count - 3'd1;
          if (status.wrap) begin
            cursor_column <= '0;
            // on the last row the scroll keeps the cursor on that row
            if (!status.last_row) begin
              cursor_row <= cursor_row + 7'd1;
            end
          end else begin
            cursor_column <= cursor_column + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      final_res   <= cmd.last;
      paper_color <= background_color;
      if (cmd.act == ACT_PUT) begin
        kind        <= KIND_WRITE;
        cell_column <= cursor_column;
        cell_row    <= cursor_row;
        glyph_code  <= (item_kind == IK_TAB) ? GLYPH_SPACE : item_char[6:0];
        ink_color   <= foreground_color;
      end else begin
        kind        <= (cmd.act == ACT_CLEAR) ? KIND_CLEAR : KIND_SCROLL;
        cell_column <= '0;
        cell_row    <= '0;
        glyph_code  <= '0;
        ink_color   <= '0;
      end
    end
  end

endmodule

### src/text_terminal_cursor_control.sv
// Text terminal cursor controller: top level joining sequencer and datapath.
// Depends on ttcc_pkg, ttcc_if, ttcc_ctrl and ttcc_datapath.
//
// Usage: commands enter on cmd (valid/ready). Put character writes a cell
// or moves the cursor; tab expands into spaces up to the next column that
// is a multiple of four; set cursor saturates to the grid; clear screen
// gives one clear result and homes the cursor. Results leave on res, one
// per cycle at most, final_res marking the last one of a command.
// Configuration (column count, row count, ink and paper colors) is written
// through cfg_we / cfg_index / cfg_data while no command is in flight.
// Sequence: a command is accepted in S_IDLE and executed from the next cycle
// on in S_EXEC. Commands without a cell write end in S_EXEC; put character
// and tab then visit S_PUT for each cell and S_SCROLL for each scroll. A
// clear or a newline scroll is emitted from S_EXEC, a cell write from S_PUT.
// The sequencer takes
// one command at a time; it accepts the next command while the final result
// of the previous one still waits in the output register.
// A stalled receiver holds the result register and the sequencer waits.
// Reset clears the cursor to the top left cell and loads the register
// defaults: 80 columns, 25 rows, white ink on dark blue paper.
module text_terminal_cursor_control
  import ttcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  ttcc_cmd_if.sink    cmd,
  ttcc_res_if.source  res
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  ttcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  ttcc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (cmd.opcode),
    .character     (cmd.character),
    .target_row    (cmd.target_row),
    .target_column (cmd.target_column),
    .cmd           (ctrl_cmd),
    .status        (dp_status),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .kind          (res.kind),
    .cell_column   (res.cell_column),
    .cell_row      (res.cell_row),
    .glyph_code    (res.glyph_code),
    .ink_color     (res.ink_color),
    .paper_color   (res.paper_color),
    .final_res     (res.final_res)
  );

endmodule

### tb/sv/text_terminal_cursor_control_tb.sv
`timescale 1ns / 1ps
// Testbench for text_terminal_cursor_control: directed command table, then random phases
// over several grid sizes and colors. Results are checked against an in-bench cursor model or typed rows.
// Depends on ttcc_pkg, ttcc_if and the RTL of the block.
module text_terminal_cursor_control_tb;
  import ttcc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_CELLS_PER_CMD = 8;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] character;
    logic [6:0] target_row;
    logic [7:0] target_column;
  } term_cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cell_column;
    logic [6:0]  cell_row;
    logic [6:0]  glyph_code;
    logic [31:0] ink_color;
    logic [31:0] paper_color;
    logic        final_res;
  } cell_op_t;

  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_NONE,
    CHECK_ONE
  } check_t;

  typedef struct packed {
    term_cmd_t cmd;
    check_t    check;
    cell_op_t  want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  ttcc_cmd_if cmd_ch();
  ttcc_res_if res_ch();

  text_terminal_cursor_control dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // Cursor model state and its copy of the registers
  int cur_col;
  int cur_row;
  logic [8:0] cols_reg;
  logic [7:0] rows_reg;
  logic [31:0] ink_reg;
  logic [31:0] paper_reg;

  cell_op_t cmd_cells[$];
  cell_op_t awaited_cells[$];
  script_row_t script[$];

  int mismatches = 0;
  int cycle_count = 0;
  bit quiet_mode = 1'b0;
  int ready_left = 0;
  int ready_pick;
  bit ready_hold;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void emit_cell(logic [1:0] kind, int col, int row, logic [6:0] glyph,
                                    logic [31:0] ink);
    cell_op_t e;
    if (cmd_cells.size() >= MAX_CELLS_PER_CMD) return;
    e.kind = kind;
    e.cell_column = 8'(col);
    e.cell_row = 7'(row);
    e.glyph_code = glyph;
    e.ink_color = ink;
    e.paper_color = paper_reg;
    e.final_res = 1'b0;
    cmd_cells.push_back(e);
  endfunction

  function automatic void feed_line(int rows);
    cur_col = 0;
    cur_row++;
    if (cur_row >= rows) begin
      emit_cell(KIND_SCROLL, 0, 0, 7'd0, 32'd0);
      cur_row = rows - 1;
    end
  endfunction

  function automatic void advance_cell(logic [7:0] ch, int cols, int rows);
    // high characters only move the cursor
    if (!ch[7])
      emit_cell(KIND_WRITE, cur_col, cur_row, ch[6:0], ink_reg);
    cur_col++;
    if (cur_col >= cols)
      feed_line(rows);
  endfunction

  function automatic void expand_command(term_cmd_t c);
    int cols;
    int rows;
    int spaces;
    cols = (cols_reg < 1) ? 1 : int'(cols_reg);
    if (cols > COL_LIMIT) cols = COL_LIMIT;
    rows = (rows_reg < 1) ? 1 : int'(rows_reg);
    if (rows > ROW_LIMIT) rows = ROW_LIMIT;
    cmd_cells.delete();
    // pull the cursor back inside a grid that shrank
    if (cur_col >= cols) cur_col = cols - 1;
    if (cur_row >= rows) cur_row = rows - 1;
    case (c.opcode)
      OP_PUT_CHAR: begin
        if (c.character == CH_NEWLINE) begin
          feed_line(rows);
        end else if (c.character == CH_RETURN) begin
          cur_col = 0;
        end else if (c.character == CH_TAB) begin
          spaces = TAB_STOP - (cur_col % TAB_STOP);
          repeat (spaces) advance_cell({1'b0, GLYPH_SPACE}, cols, rows);
        end else if (c.character == CH_BACKSPACE) begin
          if (cur_col > 0) cur_col--;
        end else begin
          advance_cell(c.character, cols, rows);
        end
      end
      OP_SET_CUR: begin
        cur_row = (c.target_row >= rows) ? rows - 1 : int'(c.target_row);
        cur_col = (c.target_column >= cols) ? cols - 1 : int'(c.target_column);
      end
      OP_CLEAR: begin
        emit_cell(KIND_CLEAR, 0, 0, 7'd0, 32'd0);
        cur_col = 0;
        cur_row = 0;
      end
      default: ;
    endcase
    if (cmd_cells.size() > 0)
      cmd_cells[cmd_cells.size() - 1].final_res = 1'b1;
  endfunction

  // Single result under the reset colors, for the typed rows of the script
  function automatic cell_op_t typed_cell(logic [1:0] kind, logic [7:0] col, logic [6:0] row,
                                          logic [6:0] glyph);
    cell_op_t e;
    e.kind = kind;
    e.cell_column = col;
    e.cell_row = row;
    e.glyph_code = glyph;
    e.ink_color = (kind == KIND_WRITE) ? FOREGROUND_RESET : 32'd0;
    e.paper_color = BACKGROUND_RESET;
    e.final_res = 1'b1;
    return e;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [7:0] ch, logic [6:0] tr,
                                  logic [7:0] tc, check_t chk, cell_op_t want = '0);
    script_row_t r;
    r.cmd.opcode = op;
    r.cmd.character = ch;
    r.cmd.target_row = tr;
    r.cmd.target_column = tc;
    r.check = chk;
    r.want = want;
    script.push_back(r);
  endfunction

  function automatic term_cmd_t random_cmd();
    term_cmd_t c;
    int pick;
    c.opcode = OP_PUT_CHAR;
    c.character = 8'($urandom_range(0, 255));
    c.target_row = 7'($urandom_range(0, 127));
    c.target_column = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      c.opcode = OP_UNUSED;
    end else if (pick < 8) begin
      c.opcode = OP_CLEAR;
    end else if (pick < 22) begin
      c.opcode = OP_SET_CUR;
      // keep half of the targets near the origin so small grids see inner cells
      if (pick[0]) begin
        c.target_row = 7'($urandom_range(0, 7));
        c.target_column = 8'($urandom_range(0, 23));
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 10) c.character = CH_NEWLINE;
      else if (pick < 16) c.character = CH_RETURN;
      else if (pick < 28) c.character = CH_TAB;
      else if (pick < 36) c.character = CH_BACKSPACE;
      else if (pick < 48) c.character = 8'($urandom_range(128, 255));
      else if (pick < 55) c.character = 8'($urandom_range(0, 31));
      else c.character = 8'($urandom_range(32, 127));
    end
    return c;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(term_cmd_t c);
    int gap;
    int pick;
    gap = 0;
    if (!quiet_mode) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) gap = $urandom_range(8, 30);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.opcode <= c.opcode;
    cmd_ch.character <= c.character;
    cmd_ch.target_row <= c.target_row;
    cmd_ch.target_column <= c.target_column;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    expand_command(c);
  endtask

  // Hold the sender until every awaited result is in, then let the block go quiet
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (awaited_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_grid(logic [8:0] cols, logic [7:0] rows, logic [31:0] ink,
                              logic [31:0] paper);
    write_reg(REG_COLUMN_COUNT, {23'd0, cols});
    write_reg(REG_ROW_COUNT, {24'd0, rows});
    write_reg(REG_FOREGROUND, ink);
    write_reg(REG_BACKGROUND, paper);
    cfg_we <= 1'b0;
    cols_reg = cols;
    rows_reg = rows;
    ink_reg = ink;
    paper_reg = paper;
  endtask

  task automatic run_phase(logic [8:0] cols, logic [7:0] rows, logic [31:0] ink,
                           logic [31:0] paper, int items, bit quiet);
    int sent;
    term_cmd_t c;
    settle();
    program_grid(cols, rows, ink, paper);
    quiet_mode = quiet;
    sent = 0;
    while (sent < items) begin
      c = random_cmd();
      send_item(c);
      foreach (cmd_cells[i]) awaited_cells.push_back(cmd_cells[i]);
      if (c.opcode != OP_UNUSED) begin
        sent++;
        if (sent == items / 2) settle();
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial res_ch.ready = 1'b0;

  // Result side: random stalls outside quiet mode, compare each accepted item with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      ready_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_cells.size() == 0) begin
          $error("result with nothing expected: kind %0d", res_ch.kind);
          mismatches++;
        end else begin
          cell_op_t w;
          w = awaited_cells.pop_front();
          check_field("kind", 32'(w.kind), 32'(res_ch.kind));
          check_field("cell_column", 32'(w.cell_column), 32'(res_ch.cell_column));
          check_field("cell_row", 32'(w.cell_row), 32'(res_ch.cell_row));
          check_field("glyph_code", 32'(w.glyph_code), 32'(res_ch.glyph_code));
          check_field("ink_color", w.ink_color, res_ch.ink_color);
          check_field("paper_color", w.paper_color, res_ch.paper_color);
          check_field("final_res", 32'(w.final_res), 32'(res_ch.final_res));
        end
      end
      if (quiet_mode) begin
        res_ch.ready <= 1'b1;
      end else begin
        if (ready_left == 0) begin
          ready_pick = $urandom_range(0, 99);
          ready_hold = (ready_pick < 50);
          if (ready_hold) ready_left = $urandom_range(1, 8);
          else if (ready_pick < 92) ready_left = $urandom_range(1, 3);
          else ready_left = $urandom_range(10, 40);
        end
        ready_left--;
        res_ch.ready <= ready_hold;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_terminal_cursor_control_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_COLUMN_COUNT;
    cfg_data <= 32'd0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.opcode <= OP_PUT_CHAR;
    cmd_ch.character <= 8'd0;
    cmd_ch.target_row <= 7'd0;
    cmd_ch.target_column <= 8'd0;
    cols_reg = COLUMN_COUNT_RESET;
    rows_reg = ROW_COUNT_RESET;
    ink_reg = FOREGROUND_RESET;
    paper_reg = BACKGROUND_RESET;
    cur_col = 0;
    cur_row = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed script on the reset grid of 80 by 25
    add_row(OP_PUT_CHAR, 8'h41, 7'd0, 8'd0, CHECK_ONE, typed_cell(KIND_WRITE, 8'd0, 7'd0, 7'h41));
    add_row(OP_PUT_CHAR, 8'h7F, 7'd0, 8'd0, CHECK_ONE, typed_cell(KIND_WRITE, 8'd1, 7'd0, 7'h7F));
    add_row(OP_PUT_CHAR, 8'hFF, 7'd0, 8'd0, CHECK_NONE);
    add_row(OP_PUT_CHAR, 8'h80, 7'd0, 8'd0, CHECK_NONE);
    add_row(OP_PUT_CHAR, 8'h00, 7'd0, 8'd0, CHECK_ONE, typed_cell(KIND_WRITE, 8'd4, 7'd0, 7'h00));
    add_row(OP_PUT_CHAR, 8'h1B, 7'd0, 8'd0, CHECK_MODEL);
    add_row(OP_PUT_CHAR, CH_BACKSPACE, 7'd0, 8'd0, CHECK_NONE);
    add_row(OP_PUT_CHAR, CH_RETURN, 7'd0, 8'd0, CHECK_NONE);
    add_row(OP_PUT_CHAR, CH_BACKSPACE, 7'd0, 8'd0, CHECK_NONE);
    add_row(OP_PUT_CHAR, CH_TAB, 7'd0, 8'd0, CHECK_MODEL);
    add_row(OP_PUT_CHAR, 8'h62, 7'd0, 8'd0, CHECK_MODEL);
    add_row(OP_PUT_CHAR, CH_TAB, 7'd0, 8'd0, CHECK_MODEL);
    add_row(OP_PUT_CHAR, CH_NEWLINE, 7'd0, 8'd0, CHECK_NONE);
    add_row(OP_SET_CUR, 8'h00, 7'd127, 8'd255, CHECK_NONE);
    add_row(OP_PUT_CHAR, 8'h7A, 7'd0, 8'd0, CHECK_MODEL);
    add_row(OP_PUT_CHAR, CH_NEWLINE, 7'd0, 8'd0, CHECK_MODEL);
    add_row(OP_SET_CUR, 8'hFF, 7'd0, 8'd78, CHECK_NONE);
    add_row(OP_PUT_CHAR, CH_TAB, 7'd0, 8'd0, CHECK_MODEL);
    add_row(OP_SET_CUR, 8'h00, 7'd127, 8'd77, CHECK_NONE);
    add_row(OP_PUT_CHAR, CH_TAB, 7'd0, 8'd0, CHECK_MODEL);
    add_row(OP_UNUSED, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
            8'($urandom_range(0, 255)), CHECK_NONE);
    add_row(OP_CLEAR, 8'h00, 7'd0, 8'd0, CHECK_ONE, typed_cell(KIND_CLEAR, 8'd0, 7'd0, 7'd0));
    add_row(OP_SET_CUR, 8'h00, 7'd0, 8'd0, CHECK_NONE);
    add_row(OP_PUT_CHAR, 8'h5A, 7'd0, 8'd0, CHECK_ONE, typed_cell(KIND_WRITE, 8'd0, 7'd0, 7'h5A));
    // leave the cursor far out so the next grid has to clip it
    add_row(OP_SET_CUR, 8'h00, 7'd30, 8'd200, CHECK_NONE);

    foreach (script[i]) begin
      send_item(script[i].cmd);
      case (script[i].check)
        CHECK_MODEL: foreach (cmd_cells[j]) awaited_cells.push_back(cmd_cells[j]);
        CHECK_ONE: awaited_cells.push_back(script[i].want);
        default: ;
      endcase
    end

    run_phase(9'd1, 8'd1, 32'h0000_0000, 32'hFFFF_FFFF, 40, 1'b0);
    run_phase(9'd0, 8'd0, 32'hFFFF_FFFF, 32'h0000_0000, 30, 1'b0);
    run_phase(9'd511, 8'd255, $urandom(), $urandom(), 60, 1'b1);
    run_phase(9'd256, 8'd128, $urandom(), $urandom(), 60, 1'b0);
    run_phase(9'd7, 8'd3, $urandom(), $urandom(), 50, 1'b0);
    run_phase(9'($urandom_range(1, 20)), 8'($urandom_range(1, 8)), $urandom(), $urandom(),
              50, 1'b0);
    run_phase(9'($urandom_range(1, 20)), 8'($urandom_range(1, 8)), $urandom(), $urandom(),
              50, 1'b0);
    run_phase(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)), $urandom(), $urandom(),
              60, 1'b0);

    settle();
    if (mismatches == 0)
      $display("text_terminal_cursor_control_tb: done, clean");
    else
      $display("text_terminal_cursor_control_tb: done, errors");
    $finish;
  end

endmodule

### text_terminal_cursor_control.f
src/ttcc_pkg.sv
src/ttcc_if.sv
src/ttcc_ctrl.sv
src/ttcc_datapath.sv
src/text_terminal_cursor_control.sv
tb/sv/text_terminal_cursor_control_tb.sv
